// ===== hw/rtl/vka_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vka_pkg
// Shared widths, codes, record type and saturating helpers for the day table.
// ----------------------------------------------------------------------------
package vka_pkg;

    localparam int DAY_SLOTS_DEF = 16;
    localparam int FRAC_BITS_DEF = 4;

    localparam int KEY_W  = 27;
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 24;
    localparam int RATE_W = 12;
    localparam int AVG_W  = 16;
    localparam int LIM_W  = 7;
    localparam int RND_W  = RATE_W + 1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_MERGE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ROW    = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [1:0] CFG_HEART_MIN  = 2'd0;
    localparam logic [1:0] CFG_HEART_MAX  = 2'd1;
    localparam logic [1:0] CFG_BREATH_MIN = 2'd2;
    localparam logic [1:0] CFG_BREATH_MAX = 2'd3;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] day;
        logic [SUM_W-1:0] hsum;
        logic [CNT_W-1:0] hcnt;
        logic [SUM_W-1:0] bsum;
        logic [CNT_W-1:0] bcnt;
    } rec_t;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vka_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vka_cell
// One slot of the day table; passes its record to the neighbour on shift.
// ----------------------------------------------------------------------------
module vka_cell import vka_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic shift_en,
    input  wire rec_t rec_in,
    output rec_t      rec_out
);

    rec_t rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.used <= 1'b0;
        end else if (shift_en) begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vka_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vka_div
// Restoring divider, one quotient bit per cycle, saturated 16-bit quotient.
// ----------------------------------------------------------------------------
module vka_div import vka_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SUM_W:0]   dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  busy,
    output logic [AVG_W-1:0]      quotient
);

    localparam int DW = SUM_W + 1;
    localparam int SW = $clog2(DW + 1);

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] div_reg;
    logic [DW-1:0]    dq_reg;
    logic [SW-1:0]    step_reg;
    logic             busy_reg;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, dq_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};
    assign diff   = rem_sh - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            rem_reg  <= '0;
            dq_reg   <= dividend;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dq_reg   <= {dq_reg[DW-2:0], ge};
            step_reg <= step_reg + SW'(1);
            if (step_reg == SW'(DW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = (|dq_reg[DW-1:AVG_W]) ? {AVG_W{1'b1}} : dq_reg[AVG_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/day_keyed_vitals_accumulator_table.sv =====
// Add and merge requests: an accept state, a search pass over all DAY_SLOTS slots,
// a pick state, a write-back pass over all slots and an output state.
// Read requests: per row a scan pass over all slots, a pick state, a divide state
// when a row is found and an output state; one request at a time.
// The row of cells rotates one slot per cycle during every pass.
// Synchronous active-low reset marks all slots free and restores the limits.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// day_keyed_vitals_accumulator_table
// Per-day heart and breath accumulator table with sorted read-out.
// ----------------------------------------------------------------------------
module day_keyed_vitals_accumulator_table import vka_pkg::*; #(
    parameter int DAY_SLOTS = DAY_SLOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // day_key, heart_present, heart_value, breath_present, breath_value,
    // merge_heart_sum, merge_heart_count, merge_breath_sum,
    // merge_breath_count, read_limit
    input  wire logic [175:0] s_tdata,
    // command
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // changed, row_day, heart count, heart_valid, heart_average,
    // breath count, breath_valid, breath_average
    output logic [111:0]      m_tdata,
    // kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [11:0]  cfg_wdata
);

    localparam int IW = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DAY_SLOTS - 1);
    localparam int TW = RATE_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_PICK, ST_APPLY, ST_RSCAN, ST_RPICK, ST_DIV, ST_ROW
    } state_t;

    // request fields
    logic [1:0]        in_cmd;
    logic [KEY_W-1:0]  in_key;
    logic              in_hp, in_bp;
    logic [RATE_W-1:0] in_hv, in_bv;
    logic [SUM_W-1:0]  in_mhs, in_mbs;
    logic [CNT_W-1:0]  in_mhc, in_mbc;
    logic [LIM_W-1:0]  in_lim;

    assign in_cmd = s_tuser;
    assign in_key = s_tdata[26:0];
    assign in_hp  = s_tdata[27];
    assign in_hv  = s_tdata[39:28];
    assign in_bp  = s_tdata[40];
    assign in_bv  = s_tdata[52:41];
    assign in_mhs = s_tdata[84:53];
    assign in_mhc = s_tdata[108:85];
    assign in_mbs = s_tdata[140:109];
    assign in_mbc = s_tdata[164:141];
    assign in_lim = s_tdata[171:165];

    logic [RATE_W-1:0] heart_min_reg, heart_max_reg, breath_min_reg, breath_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heart_min_reg  <= 12'd480;
            heart_max_reg  <= 12'd3520;
            breath_min_reg <= 12'd64;
            breath_max_reg <= 12'd960;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEART_MIN:  heart_min_reg  <= cfg_wdata;
                CFG_HEART_MAX:  heart_max_reg  <= cfg_wdata;
                CFG_BREATH_MIN: breath_min_reg <= cfg_wdata;
                CFG_BREATH_MAX: breath_max_reg <= cfg_wdata;
                default:        heart_min_reg  <= heart_min_reg;
            endcase
        end
    end

    logic              h_ok, b_ok;
    logic [TW-1:0]     h_tmp, b_tmp;
    logic [RND_W-1:0]  h_rnd, b_rnd;

    assign h_ok  = in_hp && (in_hv >= heart_min_reg) && (in_hv <= heart_max_reg);
    assign b_ok  = in_bp && (in_bv >= breath_min_reg) && (in_bv <= breath_max_reg);
    assign h_tmp = {1'b0, in_hv, 1'b0} + TW'(1 << FRAC_BITS);
    assign b_tmp = {1'b0, in_bv, 1'b0} + TW'(1 << FRAC_BITS);
    assign h_rnd = RND_W'(h_tmp >> (FRAC_BITS + 1));
    assign b_rnd = RND_W'(b_tmp >> (FRAC_BITS + 1));

    state_t            state_reg;
    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              h_ok_reg, b_ok_reg;
    logic [RND_W-1:0]  hr_reg, br_reg;
    logic [SUM_W-1:0]  mhs_reg, mbs_reg;
    logic [CNT_W-1:0]  mhc_reg, mbc_reg;
    logic [LIM_W-1:0]  limit_reg, rows_reg;
    logic [IW-1:0]     k_reg, match_i_reg, free_i_reg, min_i_reg, tgt_reg;
    logic              match_f_reg, free_f_reg, claim_reg;
    logic [KEY_W-1:0]  min_day_reg, last_key_reg;
    logic              found_reg, more_reg;
    rec_t              best_reg;
    logic [1:0]        kind_reg;
    logic              chg_reg;

    logic              m_valid_reg, m_last_reg, m_changed_reg;
    logic [1:0]        m_kind_reg;
    logic [KEY_W-1:0]  m_day_reg;
    logic [CNT_W-1:0]  m_hs_reg, m_bs_reg;
    logic              m_hv_reg, m_bv_reg;
    logic [AVG_W-1:0]  m_ha_reg, m_ba_reg;

    // chain of cells
    rec_t chain [DAY_SLOTS];
    rec_t head, tail_rec, upd_rec;
    logic shift_en;

    assign head     = chain[0];
    assign shift_en = (state_reg == ST_SCAN) || (state_reg == ST_APPLY) ||
                      (state_reg == ST_RSCAN);

    genvar gi;
    generate
        for (gi = 0; gi < DAY_SLOTS; gi++) begin : g_cell
            if (gi == DAY_SLOTS - 1) begin : g_tail
                vka_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                    .rec_in(tail_rec), .rec_out(chain[gi])
                );
            end else begin : g_mid
                vka_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                    .rec_in(chain[gi+1]), .rec_out(chain[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        rec_t base;
        base = head;
        if (claim_reg) begin
            base.hsum = '0;
            base.hcnt = '0;
            base.bsum = '0;
            base.bcnt = '0;
        end
        upd_rec      = base;
        upd_rec.used = 1'b1;
        upd_rec.day  = key_reg;
        if (cmd_reg == CMD_MERGE) begin
            upd_rec.hsum = sat_sum(base.hsum, mhs_reg);
            upd_rec.hcnt = sat_cnt(base.hcnt, mhc_reg);
            upd_rec.bsum = sat_sum(base.bsum, mbs_reg);
            upd_rec.bcnt = sat_cnt(base.bcnt, mbc_reg);
        end else begin
            if (h_ok_reg) begin
                upd_rec.hsum = sat_sum(base.hsum, SUM_W'(hr_reg));
                upd_rec.hcnt = sat_cnt(base.hcnt, CNT_W'(1));
            end
            if (b_ok_reg) begin
                upd_rec.bsum = sat_sum(base.bsum, SUM_W'(br_reg));
                upd_rec.bcnt = sat_cnt(base.bcnt, CNT_W'(1));
            end
        end
    end

    assign tail_rec = ((state_reg == ST_APPLY) && (k_reg == tgt_reg)) ? upd_rec : head;

    // averaging dividers
    logic             div_start, h_busy, b_busy;
    logic [AVG_W-1:0] h_avg, b_avg;

    assign div_start = (state_reg == ST_RPICK) && found_reg;

    vka_div u_hdiv (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({1'b0, best_reg.hsum} + (SUM_W+1)'(best_reg.hcnt >> 1)),
        .divisor(best_reg.hcnt), .busy(h_busy), .quotient(h_avg)
    );

    vka_div u_bdiv (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend({1'b0, best_reg.bsum} + (SUM_W+1)'(best_reg.bcnt >> 1)),
        .divisor(best_reg.bcnt), .busy(b_busy), .quotient(b_avg)
    );

    logic out_free, s_acc, elig, row_last;

    assign out_free = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign elig     = head.used && (head.day > last_key_reg);
    assign row_last = !more_reg || ((rows_reg + LIM_W'(1)) == limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != ST_ROW)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        cmd_reg      <= in_cmd;
                        key_reg      <= in_key;
                        h_ok_reg     <= h_ok;
                        b_ok_reg     <= b_ok;
                        hr_reg       <= h_rnd;
                        br_reg       <= b_rnd;
                        mhs_reg      <= in_mhs;
                        mhc_reg      <= in_mhc;
                        mbs_reg      <= in_mbs;
                        mbc_reg      <= in_mbc;
                        limit_reg    <= in_lim;
                        rows_reg     <= '0;
                        last_key_reg <= '0;
                        found_reg    <= 1'b0;
                        more_reg     <= 1'b0;
                        match_f_reg  <= 1'b0;
                        free_f_reg   <= 1'b0;
                        k_reg        <= '0;
                        kind_reg     <= KIND_STATUS;
                        chg_reg      <= 1'b0;
                        if (in_cmd == CMD_READ) begin
                            if (in_lim == '0) begin
                                kind_reg  <= KIND_EMPTY;
                                state_reg <= ST_ROW;
                            end else begin
                                state_reg <= ST_RSCAN;
                            end
                        end else if (in_key != '0 &&
                                     ((in_cmd == CMD_ADD && (h_ok || b_ok)) ||
                                      in_cmd == CMD_MERGE)) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_SCAN: begin
                    if (head.used && head.day == key_reg && !match_f_reg) begin
                        match_f_reg <= 1'b1;
                        match_i_reg <= k_reg;
                    end
                    if (!head.used && !free_f_reg) begin
                        free_f_reg <= 1'b1;
                        free_i_reg <= k_reg;
                    end
                    if (k_reg == '0 || head.day < min_day_reg) begin
                        min_day_reg <= head.day;
                        min_i_reg   <= k_reg;
                    end
                    k_reg <= k_reg + IW'(1);
                    if (k_reg == LAST_IDX) begin
                        k_reg     <= '0;
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    priority if (match_f_reg) begin
                        tgt_reg   <= match_i_reg;
                        claim_reg <= 1'b0;
                        state_reg <= ST_APPLY;
                    end else if (free_f_reg) begin
                        tgt_reg   <= free_i_reg;
                        claim_reg <= 1'b1;
                        state_reg <= ST_APPLY;
                    end else if (key_reg > min_day_reg) begin
                        tgt_reg   <= min_i_reg;
                        claim_reg <= 1'b1;
                        state_reg <= ST_APPLY;
                    end else begin
                        state_reg <= ST_ROW;
                    end
                end
                ST_APPLY: begin
                    k_reg <= k_reg + IW'(1);
                    if (k_reg == LAST_IDX) begin
                        k_reg     <= '0;
                        chg_reg   <= 1'b1;
                        state_reg <= ST_ROW;
                    end
                end
                ST_RSCAN: begin
                    if (elig) begin
                        if (!found_reg || head.day < best_reg.day) begin
                            best_reg <= head;
                        end
                        if (found_reg) begin
                            more_reg <= 1'b1;
                        end
                        found_reg <= 1'b1;
                    end
                    k_reg <= k_reg + IW'(1);
                    if (k_reg == LAST_IDX) begin
                        k_reg     <= '0;
                        state_reg <= ST_RPICK;
                    end
                end
                ST_RPICK: begin
                    if (found_reg) begin
                        kind_reg  <= KIND_ROW;
                        state_reg <= ST_DIV;
                    end else begin
                        kind_reg  <= KIND_EMPTY;
                        state_reg <= ST_ROW;
                    end
                end
                ST_DIV: begin
                    if (!h_busy && !b_busy) begin
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_kind_reg    <= kind_reg;
                        m_changed_reg <= chg_reg;
                        m_day_reg     <= '0;
                        m_hs_reg      <= '0;
                        m_hv_reg      <= 1'b0;
                        m_ha_reg      <= '0;
                        m_bs_reg      <= '0;
                        m_bv_reg      <= 1'b0;
                        m_ba_reg      <= '0;
                        m_last_reg    <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (kind_reg == KIND_ROW) begin
                            m_day_reg    <= best_reg.day;
                            m_hs_reg     <= best_reg.hcnt;
                            m_hv_reg     <= best_reg.hcnt != '0;
                            m_ha_reg     <= (best_reg.hcnt != '0) ? h_avg : '0;
                            m_bs_reg     <= best_reg.bcnt;
                            m_bv_reg     <= best_reg.bcnt != '0;
                            m_ba_reg     <= (best_reg.bcnt != '0) ? b_avg : '0;
                            m_last_reg   <= row_last;
                            rows_reg     <= rows_reg + LIM_W'(1);
                            last_key_reg <= best_reg.day;
                            found_reg    <= 1'b0;
                            more_reg     <= 1'b0;
                            if (!row_last) begin
                                state_reg <= ST_RSCAN;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_ba_reg, m_bv_reg, m_bs_reg, m_ha_reg, m_hv_reg,
                       m_hs_reg, m_day_reg, m_changed_reg};

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        h_busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide state");

    a_rows_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RSCAN) || (state_reg == ST_DIV)) |-> (rows_reg < limit_reg))
        else $error("read produced more rows than its limit");

    a_row_key_ascends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (best_reg.day > last_key_reg))
        else $error("row key not above previous row");

endmodule
`default_nettype wire
